[src/lzsswd_pkg.sv]
// Package for the LZSS window decompressor: sizes, reset constants and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lzsswd_pkg;

  localparam int WIN_SIZE = 256;
  localparam int PTR_W    = $clog2(WIN_SIZE);
  localparam int CNT_W    = 16;
  localparam int LEN_W    = 5;

  localparam logic [7:0]       FILL_BYTE = 8'h20;
  localparam logic [PTR_W-1:0] START_PTR = PTR_W'(8'hEF);
  localparam logic [LEN_W-1:0] MIN_COPY  = LEN_W'(2);

  typedef struct packed {
    logic load_len;
    logic rd_issue;
    logic emit;
    logic emit_lit;
  } lzsswd_cmd_t;

  typedef struct packed {
    logic room_ok;
    logic is_lit;
    logic last_rem;
    logic out_free;
  } lzsswd_sts_t;

endpackage

`default_nettype wire

[src/lzsswd_ctrl.sv]
// Controller state machine for the LZSS window decompressor.
// Depends on lzsswd_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module lzsswd_ctrl
  import lzsswd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        tok_accept,
  input  var  lzsswd_sts_t sts,
  output var  lzsswd_cmd_t cmd,
  output wire logic        busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_LIT,
    S_PRIME,
    S_COPY
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (tok_accept) state_nxt = S_START;
      end
      S_START: begin
        if (!sts.room_ok) begin
          state_nxt = S_IDLE;
        end else if (sts.is_lit) begin
          state_nxt = S_LIT;
        end else begin
          cmd.load_len = 1'b1;
          state_nxt    = S_PRIME;
        end
      end
      S_LIT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_lit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_PRIME: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_COPY;
      end
      S_COPY: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.rd_issue = 1'b1;
          if (sts.last_rem) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

[src/lzsswd_dp.sv]
// Datapath for the LZSS window decompressor: token registers, history window
// with valid bits, pointers, byte count and output register. Uses lzsswd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lzsswd_dp
  import lzsswd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             tok_accept,
  input  wire logic             in_restart,
  input  wire logic             in_is_literal,
  input  wire logic [7:0]       in_literal_byte,
  input  wire logic [7:0]       in_copy_position,
  input  wire logic [3:0]       in_copy_length_code,
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data,
  input  var  lzsswd_cmd_t      cmd,
  output var  lzsswd_sts_t      sts,
  output wire logic             out_valid,
  input  wire logic             out_stall,
  output wire logic [7:0]       out_byte,
  output wire logic             out_last_of_token,
  output wire logic             out_stream_done
);

  logic [7:0]       mem [WIN_SIZE];
  logic [WIN_SIZE-1:0] vld_r;

  logic             tok_lit_r;
  logic [7:0]       tok_byte_r;
  logic [PTR_W-1:0] tok_pos_r;
  logic [3:0]       tok_code_r;

  logic [PTR_W-1:0] wp_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] size_r;
  logic [PTR_W-1:0] src_r;
  logic [LEN_W-1:0] rem_r;

  logic [7:0]       mem_q_r;
  logic             vld_q_r;
  logic             fwd_r;
  logic [7:0]       fwd_data_r;

  logic             ov_r;
  logic [7:0]       ob_r;
  logic             olast_r;
  logic             odone_r;

  logic [7:0]       rdata;
  logic [7:0]       wdata;
  logic [CNT_W-1:0] room;
  logic [LEN_W-1:0] code_len;
  logic [LEN_W-1:0] len;
  logic [CNT_W-1:0] cnt_inc;
  logic             out_take;

  assign rdata    = fwd_r ? fwd_data_r : (vld_q_r ? mem_q_r : FILL_BYTE);
  assign wdata    = cmd.emit_lit ? tok_byte_r : rdata;
  assign room     = size_r - cnt_r;
  assign code_len = LEN_W'(tok_code_r) + MIN_COPY;
  assign len      = (room < CNT_W'(code_len)) ? room[LEN_W-1:0] : code_len;
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign out_take = ov_r && !out_stall;

  assign sts.room_ok  = (cnt_r < size_r);
  assign sts.is_lit   = tok_lit_r;
  assign sts.last_rem = (rem_r == LEN_W'(1));
  assign sts.out_free = !ov_r || !out_stall;

  // history window storage
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mem[wp_r] <= wdata;
    end
    if (cmd.rd_issue) begin
      mem_q_r <= mem[src_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tok_accept) begin
      tok_lit_r  <= in_is_literal;
      tok_byte_r <= in_literal_byte;
      tok_pos_r  <= in_copy_position;
      tok_code_r <= in_copy_length_code;
    end
    if (cmd.load_len) begin
      rem_r <= len;
      src_r <= tok_pos_r;
    end else begin
      if (cmd.emit && !cmd.emit_lit) rem_r <= rem_r - LEN_W'(1);
      if (cmd.rd_issue) src_r <= src_r + PTR_W'(1);
    end
    if (cmd.rd_issue) begin
      vld_q_r    <= vld_r[src_r];
      fwd_r      <= cmd.emit && (wp_r == src_r);
      fwd_data_r <= wdata;
    end
    if (cmd.emit) begin
      ob_r    <= wdata;
      olast_r <= cmd.emit_lit || (rem_r == LEN_W'(1));
      odone_r <= (cnt_inc == size_r);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      wp_r   <= START_PTR;
      cnt_r  <= '0;
      size_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) size_r <= cfg_wr_data;
      if (tok_accept && in_restart) begin
        vld_r <= '0;
        wp_r  <= START_PTR;
        cnt_r <= '0;
      end else if (cmd.emit) begin
        vld_r[wp_r] <= 1'b1;
        wp_r        <= wp_r + PTR_W'(1);
        cnt_r       <= cnt_inc;
      end
      if (cmd.emit) begin
        ov_r <= 1'b1;
      end else if (out_take) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid         = ov_r;
  assign out_byte          = ob_r;
  assign out_last_of_token = olast_r;
  assign out_stream_done   = odone_r;

endmodule

`default_nettype wire

[src/lzss_window_decompressor_top.sv]
// LZSS window decompressor with a 256-byte history: one token is accepted when
// the block is idle; a copy is served by the registered window read that yields
// one byte a cycle while the output is not stalled. Reset or a restart token
// refills the window with 0x20 at once through per-entry valid bits, so there
// is no clearing pass.
// Top level: instantiates lzsswd_ctrl and lzsswd_dp, uses lzsswd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lzss_window_decompressor_top
  import lzsswd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output wire logic             in_stall,
  input  wire logic             in_restart,
  input  wire logic             in_is_literal,
  input  wire logic [7:0]       in_literal_byte,
  input  wire logic [7:0]       in_copy_position,
  input  wire logic [3:0]       in_copy_length_code,
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data,
  output wire logic             out_valid,
  input  wire logic             out_stall,
  output wire logic [7:0]       out_byte,
  output wire logic             out_last_of_token,
  output wire logic             out_stream_done
);

  lzsswd_cmd_t cmd;
  lzsswd_sts_t sts;
  logic        busy;
  logic        tok_accept;

  assign in_stall   = busy;
  assign tok_accept = in_valid && !busy;

  lzsswd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_accept (tok_accept),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  lzsswd_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .tok_accept          (tok_accept),
    .in_restart          (in_restart),
    .in_is_literal       (in_is_literal),
    .in_literal_byte     (in_literal_byte),
    .in_copy_position    (in_copy_position),
    .in_copy_length_code (in_copy_length_code),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_last_of_token   (out_last_of_token),
    .out_stream_done     (out_stream_done)
  );

endmodule

`default_nettype wire
